### hdl/assert_macros.svh
// Assertion macros used by the timer queue sequencer.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/dltq_pkg.sv
// Types and constants for the delta-list timer queue.
// No dependencies.
package dltq_pkg;

   localparam int MODE_W  = 3;
   localparam int SLOT_W  = 4;
   localparam int DELAY_W = 32;
   localparam int PROC_W  = 8;
   localparam int KIND_W  = 2;
   localparam int VALUE_W = 32;
   localparam int TPS_W   = 10;
   localparam logic [TPS_W-1:0] TPS_RESET = 10'd20;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 3'd0,
      MODE_ARM     = 3'd1,
      MODE_WAIT    = 3'd2,
      MODE_CANCEL  = 3'd3,
      MODE_REARM   = 3'd4,
      MODE_RELEASE = 3'd5,
      MODE_UPTIME  = 3'd6,
      MODE_BAD     = 3'd7
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_WAKE   = 2'd1,
      KIND_STATUS = 2'd2,
      KIND_VALUE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SLOT_FREE   = 2'd0,
      SLOT_SOLO   = 2'd1,
      SLOT_ACTIVE = 2'd2
   } slot_state_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [SLOT_W-1:0]  slot;
      logic [DELAY_W-1:0] delay;
      logic [PROC_W-1:0]  process;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  out_slot;
      logic [PROC_W-1:0]  wake_process;
      logic               wake_valid;
      logic               was_cancelled;
      logic               ok;
      logic               led;
      logic               rotate;
      logic [VALUE_W-1:0] value;
      logic               last;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_IDLE, OP_NOP, OP_TICK_INC, OP_DIV, OP_TICK_LED, OP_EXP_RD, OP_EXP_CHK,
      OP_TICK_DONE, OP_ARM, OP_FAIL, OP_WAIT_CANC, OP_WAIT_OWN, OP_WAIT_D,
      OP_CAN0, OP_CAN1, OP_CAN_EMIT, OP_REARM, OP_REL_FIN, OP_UPTIME, OP_EMIT_OK,
      OP_RM0, OP_RM1, OP_RM2, OP_INS_EMPTY, OP_INS0, OP_INS1, OP_INS2, OP_INS3,
      OP_INS4, OP_INS5
   } op_type;

   typedef struct packed {
      op_type op;
      logic   accept;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     live;
      logic     active;
      logic     solo;
      logic     cancelled;
      logic     nonempty;
      logic     div_last;
      logic     exp_zero;
      logic     rm_lone;
      logic     ins_more;
   } stat_type;

endpackage

### hdl/dltq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dltq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### hdl/dltq_ctrl.sv
// Sequencer for the timer queue: decodes a request and steps the datapath.
// Depends on dltq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dltq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dltq_pkg::stat_type st,
   output dltq_pkg::cmd_type  cmd
);
   import dltq_pkg::*;

   typedef enum logic [30:0] {
      S_IDLE      = 31'd1,
      S_DISPATCH  = 31'd1 << 1,
      S_TICK_INC  = 31'd1 << 2,
      S_DIV       = 31'd1 << 3,
      S_TICK_LED  = 31'd1 << 4,
      S_EXP_RD    = 31'd1 << 5,
      S_EXP_CHK   = 31'd1 << 6,
      S_TICK_DONE = 31'd1 << 7,
      S_ARM       = 31'd1 << 8,
      S_FAIL      = 31'd1 << 9,
      S_WAIT_CANC = 31'd1 << 10,
      S_WAIT_OWN  = 31'd1 << 11,
      S_WAIT_D    = 31'd1 << 12,
      S_CAN0      = 31'd1 << 13,
      S_CAN1      = 31'd1 << 14,
      S_CAN_EMIT  = 31'd1 << 15,
      S_REARM     = 31'd1 << 16,
      S_REL_FIN   = 31'd1 << 17,
      S_UPTIME    = 31'd1 << 18,
      S_EMIT_OK   = 31'd1 << 19,
      S_RM0       = 31'd1 << 20,
      S_RM1       = 31'd1 << 21,
      S_RM2       = 31'd1 << 22,
      S_RM_DONE   = 31'd1 << 23,
      S_INS_EMPTY = 31'd1 << 24,
      S_INS0      = 31'd1 << 25,
      S_INS1      = 31'd1 << 26,
      S_INS2      = 31'd1 << 27,
      S_INS3      = 31'd1 << 28,
      S_INS4      = 31'd1 << 29,
      S_INS5      = 31'd1 << 30
   } state_type;

   typedef enum logic [1:0] {
      RET_EXP, RET_CAN, RET_REARM, RET_REL
   } ret_type;

   state_type state_ff, state_in;
   ret_type   ret_ff, ret_in;
   state_type ins_entry;

   // insertion into an empty list is a single write step
   assign ins_entry = st.nonempty ? S_INS0 : S_INS_EMPTY;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         S_IDLE:      if (start) state_in = S_DISPATCH;
         S_DISPATCH: begin
            ret_in = RET_REL;
            unique case (st.mode)
               MODE_TICK:    state_in = S_TICK_INC;
               MODE_ARM:     state_in = S_ARM;
               MODE_WAIT: begin
                  if (!st.live)          state_in = S_FAIL;
                  else if (st.cancelled) state_in = S_WAIT_CANC;
                  else                   state_in = S_WAIT_OWN;
               end
               MODE_CANCEL:  state_in = st.active ? S_CAN0 : S_FAIL;
               MODE_REARM:   state_in = (!st.live || st.cancelled) ? S_FAIL : S_REARM;
               MODE_RELEASE: begin
                  if (!st.live)       state_in = S_FAIL;
                  else if (st.active) state_in = S_RM0;
                  else                state_in = S_REL_FIN;
               end
               MODE_UPTIME:  state_in = S_UPTIME;
               MODE_BAD:     state_in = S_FAIL;
               default:      state_in = S_FAIL;
            endcase
         end
         S_TICK_INC:  state_in = S_DIV;
         S_DIV:       if (st.div_last) state_in = S_TICK_LED;
         S_TICK_LED:  state_in = S_EXP_RD;
         S_EXP_RD:    state_in = st.nonempty ? S_EXP_CHK : S_TICK_DONE;
         S_EXP_CHK: begin
            ret_in   = RET_EXP;
            state_in = st.exp_zero ? S_RM0 : S_TICK_DONE;
         end
         S_TICK_DONE, S_ARM, S_FAIL, S_WAIT_CANC, S_CAN_EMIT, S_REL_FIN, S_UPTIME,
         S_EMIT_OK:   state_in = S_IDLE;
         S_WAIT_OWN:  state_in = st.solo ? S_WAIT_D : S_EMIT_OK;
         S_WAIT_D:    state_in = ins_entry;
         S_CAN0:      state_in = S_CAN1;
         S_CAN1: begin
            ret_in   = RET_CAN;
            state_in = S_RM0;
         end
         S_REARM: begin
            ret_in   = RET_REARM;
            state_in = st.active ? S_RM0 : ins_entry;
         end
         S_RM0:       state_in = S_RM1;
         S_RM1:       state_in = st.rm_lone ? S_RM_DONE : S_RM2;
         S_RM2:       state_in = S_RM_DONE;
         S_RM_DONE: begin
            unique case (ret_ff)
               RET_EXP:   state_in = S_EXP_RD;
               RET_CAN:   state_in = S_CAN_EMIT;
               RET_REARM: state_in = ins_entry;
               RET_REL:   state_in = S_REL_FIN;
               default:   state_in = S_IDLE;
            endcase
         end
         S_INS_EMPTY: state_in = S_EMIT_OK;
         S_INS0:      state_in = S_INS1;
         S_INS1:      state_in = S_INS2;
         S_INS2:      state_in = st.ins_more ? S_INS3 : S_INS4;
         S_INS3:      state_in = S_INS2;
         S_INS4:      state_in = S_INS5;
         S_INS5:      state_in = S_EMIT_OK;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.accept = (state_ff == S_IDLE) && start;
      unique case (state_ff)
         S_IDLE:      cmd.op = OP_IDLE;
         S_TICK_INC:  cmd.op = OP_TICK_INC;
         S_DIV:       cmd.op = OP_DIV;
         S_TICK_LED:  cmd.op = OP_TICK_LED;
         S_EXP_RD:    cmd.op = OP_EXP_RD;
         S_EXP_CHK:   cmd.op = OP_EXP_CHK;
         S_TICK_DONE: cmd.op = OP_TICK_DONE;
         S_ARM:       cmd.op = OP_ARM;
         S_FAIL:      cmd.op = OP_FAIL;
         S_WAIT_CANC: cmd.op = OP_WAIT_CANC;
         S_WAIT_OWN:  cmd.op = OP_WAIT_OWN;
         S_WAIT_D:    cmd.op = OP_WAIT_D;
         S_CAN0:      cmd.op = OP_CAN0;
         S_CAN1:      cmd.op = OP_CAN1;
         S_CAN_EMIT:  cmd.op = OP_CAN_EMIT;
         S_REARM:     cmd.op = OP_REARM;
         S_REL_FIN:   cmd.op = OP_REL_FIN;
         S_UPTIME:    cmd.op = OP_UPTIME;
         S_EMIT_OK:   cmd.op = OP_EMIT_OK;
         S_RM0:       cmd.op = OP_RM0;
         S_RM1:       cmd.op = OP_RM1;
         S_RM2:       cmd.op = OP_RM2;
         S_INS_EMPTY: cmd.op = OP_INS_EMPTY;
         S_INS0:      cmd.op = OP_INS0;
         S_INS1:      cmd.op = OP_INS1;
         S_INS2:      cmd.op = OP_INS2;
         S_INS3:      cmd.op = OP_INS3;
         S_INS4:      cmd.op = OP_INS4;
         S_INS5:      cmd.op = OP_INS5;
         default:     cmd.op = OP_NOP;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_EXP;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_ALWAYS(a_exp_nonempty, clock, reset, (state_ff != S_EXP_CHK) || st.nonempty)
   `ASSERT_ALWAYS(a_ins_nonempty, clock, reset, (state_ff != S_INS0) || st.nonempty)
   `ASSERT_NEXT(a_done_idle, clock, reset, state_ff == S_TICK_DONE, !busy)
endmodule

### hdl/dltq_dp.sv
// Datapath of the timer queue: slot tables, delta list RAMs, uptime,
// heartbeat divider and result register. Depends on dltq_pkg, dltq_ram.
module dltq_dp #(
   parameter int EVENTS  = 16,
   parameter int QUANTUM = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dltq_pkg::cmd_type             cmd,
   output dltq_pkg::stat_type            st,
   input  dltq_pkg::req_type             req_data,
   input  logic                          csr_we,
   input  logic [dltq_pkg::TPS_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   output dltq_pkg::rsp_type             rsp_data
);
   import dltq_pkg::*;

   localparam int IW = $clog2(EVENTS);
   localparam int QW = $clog2(QUANTUM) + 1;
   localparam int CW = $clog2(VALUE_W);

   req_type              req_ff, req_in;
   logic [IW-1:0]        s_ff, s_in, head_ff, head_in;
   logic                 nonempty_ff, nonempty_in;
   logic [VALUE_W-1:0]   uptime_ff, uptime_in;
   logic                 led_ff, led_in, rot_ff, rot_in;
   logic [TPS_W-1:0]     tps_ff, tps_in, tps_eff;
   slot_state_type       stat_ff [EVENTS];
   slot_state_type       stat_in [EVENTS];
   logic [EVENTS-1:0]    ov_ff, ov_in, cn_ff, cn_in;
   logic [IW-1:0]        n_ff, n_in, p_ff, p_in, t_ff, t_in;
   logic [IW-1:0]        last_ff, last_in, pos_ff, pos_in;
   logic [DELAY_W-1:0]   ds_ff, ds_in, d_ff, d_in, psum_ff, psum_in;
   logic [DELAY_W-1:0]   dpos_ff, dpos_in;
   logic [DELAY_W:0]     sum_ff, sum_in;
   logic                 add_ff, add_in, caseb_ff, caseb_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   sh_ff, sh_in;
   logic [TPS_W-1:0]     rt_ff, rt_in;
   logic [QW-1:0]        qc_ff, qc_in;
   logic                 wv_ff, wv_in;
   logic [PROC_W-1:0]    wproc_ff, wproc_in;
   rsp_type              rsp_ff, rsp_in, blank;
   logic                 rsp_v_ff, rsp_v_in;

   logic [TPS_W:0]       tt;
   logic                 caseb_now, wv_now;
   logic [IW-1:0]        pos_now, free_idx, raddr;
   logic                 free_found;

   logic                 d_we, nx_we, pv_we, ow_we;
   logic [IW-1:0]        d_wa, nx_wa, pv_wa, ow_wa;
   logic [DELAY_W-1:0]   d_wd, q_delta;
   logic [IW-1:0]        nx_wd, pv_wd, q_next, q_prev;
   logic [PROC_W-1:0]    ow_wd, q_owner;

   dltq_ram #(.WIDTH(DELAY_W), .DEPTH(EVENTS)) u_delta (
      .clock, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(raddr), .rdata(q_delta));
   dltq_ram #(.WIDTH(IW), .DEPTH(EVENTS)) u_next (
      .clock, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(raddr), .rdata(q_next));
   dltq_ram #(.WIDTH(IW), .DEPTH(EVENTS)) u_prev (
      .clock, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(raddr), .rdata(q_prev));
   dltq_ram #(.WIDTH(PROC_W), .DEPTH(EVENTS)) u_owner (
      .clock, .we(ow_we), .waddr(ow_wa), .wdata(ow_wd), .raddr(raddr), .rdata(q_owner));

   assign tps_eff = (tps_ff == '0) ? TPS_W'(1) : tps_ff;

   // lowest free slot
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = EVENTS - 1; i >= 0; i--) begin
         if (stat_ff[i] == SLOT_FREE) begin
            free_idx   = IW'(i);
            free_found = 1'b1;
         end
      end
   end

   always_comb begin
      blank      = '0;
      blank.led  = led_ff;
      blank.last = 1'b1;
      blank.kind = KIND_STATUS;
   end

   // end of the walk: either past every entry or stopped at the first
   // entry whose running sum reaches the delay
   assign caseb_now = !(sum_ff < {1'b0, d_ff});
   assign pos_now   = caseb_now ? last_ff : head_ff;
   assign wv_now    = ov_ff[head_ff] && !cn_ff[head_ff];

   always_comb begin
      st.mode      = mode_type'(req_ff.mode);
      st.live      = (32'(req_ff.slot) < EVENTS) && (stat_ff[s_ff] != SLOT_FREE);
      st.active    = (32'(req_ff.slot) < EVENTS) && (stat_ff[s_ff] == SLOT_ACTIVE);
      st.solo      = (stat_ff[s_ff] == SLOT_SOLO);
      st.cancelled = cn_ff[s_ff];
      st.nonempty  = nonempty_ff;
      st.div_last  = (cnt_ff == {CW{1'b1}});
      st.exp_zero  = (q_delta == '0);
      st.rm_lone   = (head_ff == s_ff) && (q_next == s_ff);
      st.ins_more  = (sum_ff < {1'b0, d_ff}) && (t_ff != head_ff);
   end

   always_comb begin
      req_in = req_ff;  s_in = s_ff;  head_in = head_ff;  nonempty_in = nonempty_ff;
      uptime_in = uptime_ff;  led_in = led_ff;  rot_in = rot_ff;
      stat_in = stat_ff;  ov_in = ov_ff;  cn_in = cn_ff;
      n_in = n_ff;  p_in = p_ff;  t_in = t_ff;  last_in = last_ff;  pos_in = pos_ff;
      ds_in = ds_ff;  d_in = d_ff;  psum_in = psum_ff;  dpos_in = dpos_ff;
      sum_in = sum_ff;  add_in = add_ff;  caseb_in = caseb_ff;
      cnt_in = cnt_ff;  sh_in = sh_ff;  rt_in = rt_ff;  qc_in = qc_ff;
      wv_in = wv_ff;  wproc_in = wproc_ff;
      rsp_in = rsp_ff;  rsp_v_in = 1'b0;
      tps_in = csr_we ? csr_wdata : tps_ff;
      raddr = s_ff;
      d_we = 1'b0;  d_wa = s_ff;  d_wd = d_ff;
      nx_we = 1'b0; nx_wa = s_ff; nx_wd = s_ff;
      pv_we = 1'b0; pv_wa = s_ff; pv_wd = s_ff;
      ow_we = 1'b0; ow_wa = s_ff; ow_wd = req_ff.process;
      tt = {rt_ff, sh_ff[VALUE_W-1]};

      unique case (cmd.op)
         OP_IDLE: begin
            if (cmd.accept) begin
               req_in = req_data;
               s_in   = IW'(req_data.slot);
            end
         end
         OP_NOP: ;
         OP_TICK_INC: begin
            uptime_in = uptime_ff + 32'd1;
            sh_in     = uptime_ff + 32'd1;
            cnt_in    = '0;
            rt_in     = '0;
            // uptime mod QUANTUM, restarted when the uptime wraps to zero
            if ((uptime_ff == '1) || (qc_ff == QW'(QUANTUM - 1))) qc_in = '0;
            else qc_in = qc_ff + QW'(1);
         end
         OP_DIV: begin
            // one quotient bit a cycle for the heartbeat remainder
            sh_in  = sh_ff << 1;
            cnt_in = cnt_ff + CW'(1);
            rt_in  = (tt >= {1'b0, tps_eff}) ? TPS_W'(tt - {1'b0, tps_eff}) : TPS_W'(tt);
         end
         OP_TICK_LED: begin
            if (rt_ff == '0) led_in = ~led_ff;
            rot_in = (qc_ff == '0);
         end
         OP_EXP_RD: raddr = head_ff;
         OP_EXP_CHK: begin
            if (q_delta == '0) begin
               rsp_in              = blank;
               rsp_in.kind         = KIND_WAKE;
               rsp_in.out_slot     = SLOT_W'(head_ff);
               rsp_in.wake_valid   = wv_now;
               rsp_in.wake_process = wv_now ? q_owner : '0;
               rsp_in.ok           = 1'b1;
               rsp_in.last         = 1'b0;
               rsp_v_in            = 1'b1;
               s_in                = head_ff;
               stat_in[head_ff]    = SLOT_SOLO;
               ov_in[head_ff]      = 1'b0;
            end else begin
               d_we = 1'b1;
               d_wa = head_ff;
               d_wd = q_delta - 32'd1;
            end
         end
         OP_TICK_DONE: begin
            rsp_in        = blank;
            rsp_in.kind   = KIND_TICK;
            rsp_in.ok     = 1'b1;
            rsp_in.rotate = rot_ff;
            rsp_v_in      = 1'b1;
         end
         OP_ARM: begin
            rsp_in   = blank;
            rsp_v_in = 1'b1;
            if (free_found) begin
               stat_in[free_idx] = SLOT_SOLO;
               ov_in[free_idx]   = 1'b0;
               cn_in[free_idx]   = 1'b0;
               d_we              = 1'b1;
               d_wa              = free_idx;
               d_wd              = req_ff.delay;
               rsp_in.out_slot   = SLOT_W'(free_idx);
               rsp_in.ok         = 1'b1;
            end
         end
         OP_FAIL: begin
            rsp_in   = blank;
            rsp_v_in = 1'b1;
         end
         OP_WAIT_CANC: begin
            rsp_in               = blank;
            rsp_in.ok            = 1'b1;
            rsp_in.was_cancelled = 1'b1;
            rsp_v_in             = 1'b1;
         end
         OP_WAIT_OWN: begin
            ow_we       = 1'b1;
            ov_in[s_ff] = 1'b1;
            if (stat_ff[s_ff] == SLOT_SOLO) stat_in[s_ff] = SLOT_ACTIVE;
         end
         OP_WAIT_D: d_in = q_delta;
         OP_CAN0: ;
         OP_CAN1: begin
            wv_in         = ov_ff[s_ff];
            wproc_in      = ov_ff[s_ff] ? q_owner : '0;
            stat_in[s_ff] = SLOT_SOLO;
            cn_in[s_ff]   = 1'b1;
            ov_in[s_ff]   = 1'b0;
         end
         OP_CAN_EMIT: begin
            rsp_in              = blank;
            rsp_in.ok           = 1'b1;
            rsp_in.wake_valid   = wv_ff;
            rsp_in.wake_process = wproc_ff;
            rsp_v_in            = 1'b1;
         end
         OP_REARM: begin
            d_in          = req_ff.delay;
            stat_in[s_ff] = SLOT_ACTIVE;
         end
         OP_REL_FIN: begin
            stat_in[s_ff]        = SLOT_FREE;
            ov_in[s_ff]          = 1'b0;
            rsp_in               = blank;
            rsp_in.ok            = 1'b1;
            rsp_in.was_cancelled = cn_ff[s_ff];
            rsp_v_in             = 1'b1;
         end
         OP_UPTIME: begin
            rsp_in       = blank;
            rsp_in.kind  = KIND_VALUE;
            rsp_in.ok    = 1'b1;
            rsp_in.value = uptime_ff;
            rsp_v_in     = 1'b1;
         end
         OP_EMIT_OK: begin
            rsp_in    = blank;
            rsp_in.ok = 1'b1;
            rsp_v_in  = 1'b1;
         end
         OP_RM0: ;
         OP_RM1: begin
            n_in  = q_next;
            p_in  = q_prev;
            ds_in = q_delta;
            raddr = q_next;
            if ((head_ff == s_ff) && (q_next == s_ff)) begin
               nonempty_in = 1'b0;
            end else begin
               if (head_ff == s_ff) head_in = q_next;
               // successor of the tail is the head: nothing to carry
               add_in = (head_ff == s_ff) || (q_next != head_ff);
            end
         end
         OP_RM2: begin
            d_we  = add_ff;
            d_wa  = n_ff;
            d_wd  = q_delta + ds_ff;
            nx_we = 1'b1;  nx_wa = p_ff;  nx_wd = n_ff;
            pv_we = 1'b1;  pv_wa = n_ff;  pv_wd = p_ff;
         end
         OP_INS_EMPTY: begin
            head_in     = s_ff;
            nonempty_in = 1'b1;
            nx_we = 1'b1;
            pv_we = 1'b1;
            d_we  = 1'b1;
         end
         OP_INS0: raddr = head_ff;
         OP_INS1: begin
            sum_in  = {1'b0, q_delta};
            t_in    = q_next;
            psum_in = '0;
            last_in = head_ff;
         end
         OP_INS2: begin
            if (st.ins_more) begin
               raddr = t_ff;
            end else begin
               caseb_in = caseb_now;
               pos_in   = pos_now;
               ds_in    = caseb_now ? (d_ff - psum_ff) : (d_ff - sum_ff[DELAY_W-1:0]);
               dpos_in  = DELAY_W'(sum_ff - {1'b0, psum_ff});
               raddr    = pos_now;
            end
         end
         OP_INS3: begin
            psum_in = sum_ff[DELAY_W-1:0];
            last_in = t_ff;
            sum_in  = sum_ff + {1'b0, q_delta};
            t_in    = q_next;
         end
         OP_INS4: begin
            p_in  = q_prev;
            nx_we = 1'b1;  nx_wa = s_ff;  nx_wd = pos_ff;
            pv_we = 1'b1;  pv_wa = s_ff;  pv_wd = q_prev;
            d_we  = 1'b1;  d_wa  = s_ff;  d_wd  = ds_ff;
         end
         OP_INS5: begin
            nx_we = 1'b1;  nx_wa = p_ff;   nx_wd = s_ff;
            pv_we = 1'b1;  pv_wa = pos_ff; pv_wd = s_ff;
            d_we  = caseb_ff;
            d_wa  = pos_ff;
            d_wd  = dpos_ff - ds_ff;
            if (caseb_ff && (pos_ff == head_ff)) head_in = s_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         uptime_ff   <= '0;
         qc_ff       <= '0;
         led_ff      <= 1'b0;
         tps_ff      <= TPS_RESET;
         ov_ff       <= '0;
         cn_ff       <= '0;
         rsp_v_ff    <= 1'b0;
         for (int i = 0; i < EVENTS; i++) begin
            stat_ff[i] <= SLOT_FREE;
         end
      end else begin
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         uptime_ff   <= uptime_in;
         qc_ff       <= qc_in;
         led_ff      <= led_in;
         tps_ff      <= tps_in;
         ov_ff       <= ov_in;
         cn_ff       <= cn_in;
         rsp_v_ff    <= rsp_v_in;
         stat_ff     <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;  s_ff <= s_in;  rot_ff <= rot_in;
      n_ff <= n_in;  p_ff <= p_in;  t_ff <= t_in;  last_ff <= last_in;  pos_ff <= pos_in;
      ds_ff <= ds_in;  d_ff <= d_in;  psum_ff <= psum_in;  dpos_ff <= dpos_in;
      sum_ff <= sum_in;  add_ff <= add_in;  caseb_ff <= caseb_in;
      cnt_ff <= cnt_in;  sh_ff <= sh_in;  rt_ff <= rt_in;
      wv_ff <= wv_in;  wproc_ff <= wproc_in;  rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;
endmodule

### hdl/delta_list_timer_queue_top.sv
// Top level of the delta-list timer queue: sequencer plus datapath.
// Depends on dltq_pkg, dltq_ctrl, dltq_dp, dltq_ram.
//
// One request is taken when start is high and busy is low; busy stays high
// until the last result word has been issued. Results come one per cycle
// slot on rsp_valid and cannot be held off, so the receiver must take every
// word as it appears; rsp_data.last marks the final word of a request.
// A tick's length is set by the uptime update and the bit-serial remainder
// unit that drives the heartbeat (one bit a cycle over 32 bits), and each
// expired entry adds a removal from the list; rotate comes from a phase
// counter that follows the uptime. Wait and rearm walk the delta list through
// the list RAMs entry by entry. No clearing pass is needed after reset.
module delta_list_timer_queue_top #(
   parameter int EVENTS  = 16,
   parameter int QUANTUM = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  dltq_pkg::req_type          req_data,
   output logic                       rsp_valid,
   output dltq_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [dltq_pkg::TPS_W-1:0] csr_wdata
);
   import dltq_pkg::*;

   cmd_type  cmd;
   stat_type st;

   dltq_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .st, .cmd
   );

   dltq_dp #(.EVENTS(EVENTS), .QUANTUM(QUANTUM)) u_dp (
      .clock, .reset, .cmd, .st, .req_data, .csr_we, .csr_wdata, .rsp_valid, .rsp_data
   );
endmodule
